// ===== src/cfcr_pkg.sv =====
package cfcr_pkg;

  localparam int DATA_FIELD_LEN = 250;
  localparam int MAX_FRAME_LEN  = 255;

  // Frame positions of the header fields.
  localparam logic [7:0] POS_TYPE    = 8'd1;
  localparam logic [7:0] POS_CRC_LO  = 8'd3;
  localparam logic [7:0] POS_CRC_HI  = 8'd4;
  localparam logic [7:0] POS_DATA    = 8'd5;
  localparam logic [8:0] POS_DATA_END = 9'(5 + DATA_FIELD_LEN);
  localparam logic [7:0] POS_MAX     = 8'(MAX_FRAME_LEN);
  localparam logic [7:0] DATA_LEN    = 8'(DATA_FIELD_LEN);
  localparam logic [7:0] COLOUR_LEN  = 8'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] START_RESET  = 8'hFF;
  localparam logic [7:0] END_RESET    = 8'h0A;
  localparam logic [7:0] COLOUR_RESET = 8'h03;

  localparam logic [1:0] REG_START_MARKER   = 2'd0;
  localparam logic [1:0] REG_END_MARKER     = 2'd1;
  localparam logic [1:0] REG_COLOUR_COMMAND = 2'd2;

  typedef struct packed {
    logic init;   // restart the remainder at the initial value
    logic load;   // load a new byte into the shifter
    logic step;   // process one bit, MSB first
  } crc_ctl_t;

endpackage

// ===== src/cfcr_crc_unit.sv =====
module cfcr_crc_unit
  import cfcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  crc_ctl_t    ctl,
  input  logic [7:0]  data_in,
  output logic [15:0] crc
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sr_r, sr_nxt;
  logic        fb;

  // After eight steps the shifter is all zeros, so padding bytes need no reload.
  always_comb begin
    fb      = crc_r[15] ^ sr_r[7];
    crc_nxt = crc_r;
    sr_nxt  = sr_r;
    if (ctl.step) begin
      crc_nxt = {crc_r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      sr_nxt  = {sr_r[6:0], 1'b0};
    end
    if (ctl.init) begin
      crc_nxt = CRC_INIT;
    end
    if (ctl.load) begin
      sr_nxt = data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      sr_r  <= 8'h00;
    end else begin
      crc_r <= crc_nxt;
      sr_r  <= sr_nxt;
    end
  end

  assign crc = crc_r;

endmodule

// ===== src/crc_checked_frame_receiver.sv =====
// Header bytes and ignored bytes are taken without holding off input. After a
// data byte, input waits while the shared bit-serial CRC unit takes one CRC bit
// per cycle. Closing a frame feeds one zero padding byte per missing data byte
// (up to 250) to the CRC, then writes the result register once the output is free.
// A finished result waits in the output register while new bytes are taken.
// Synchronous active-low reset restores the marker registers and clears colour.
module crc_checked_frame_receiver
  import cfcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: rx_byte[7:0]
  input  logic [7:0]  in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: frame_kind[7:0], crc_match[8], overrun[9], colour_loaded[10],
  //            red_level[18:11], green_level[26:19], blue_level[34:27], zero[39:35]
  output logic [39:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_DONE, S_OVR} state_t;

  state_t      state_r, state_nxt;
  logic [7:0]  start_r, end_r, cmd_r;
  logic        open_r, open_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  col0_r, col1_r, col2_r, col0_nxt, col1_nxt, col2_nxt;
  logic [23:0] colour_r, colour_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  pad_r, pad_nxt;
  logic        closing_r, closing_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r, out_data_nxt;

  logic        accept, opening, eff_open, is_close, is_data, out_free, load;
  logic [7:0]  p, done_cnt, pad_cnt, cidx;
  logic [15:0] crc;
  crc_ctl_t    ctl;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign opening   = !open_r && (in_tdata == start_r);
  assign eff_open  = open_r || opening;
  assign p         = open_r ? pos_r : 8'd0;
  assign is_close  = (in_tdata == end_r);
  assign is_data   = (p >= POS_DATA) && ({1'b0, p} < POS_DATA_END);
  assign cidx      = p - POS_DATA;
  assign out_free  = !out_valid_r || out_tready;
  assign load      = (type_r == cmd_r);

  always_comb begin
    if (p < POS_DATA) begin
      done_cnt = 8'd0;
    end else if ((p - (POS_DATA - 8'd1)) > DATA_LEN) begin
      done_cnt = DATA_LEN;
    end else begin
      done_cnt = p - (POS_DATA - 8'd1);
    end
    pad_cnt = DATA_LEN - done_cnt;
  end

  assign ctl.init = accept && opening;
  assign ctl.load = accept && eff_open && is_data;
  assign ctl.step = (state_r == S_STEP);

  cfcr_crc_unit u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .data_in (in_tdata),
    .crc     (crc)
  );

  always_comb begin
    state_nxt     = state_r;
    open_nxt      = open_r;
    pos_nxt       = pos_r;
    rcrc_nxt      = rcrc_r;
    type_nxt      = type_r;
    col0_nxt      = col0_r;
    col1_nxt      = col1_r;
    col2_nxt      = col2_r;
    colour_nxt    = colour_r;
    bit_nxt       = bit_r;
    pad_nxt       = pad_r;
    closing_nxt   = closing_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept && eff_open) begin
          if (opening) begin
            rcrc_nxt = 16'h0000;
            type_nxt = 8'h00;
            col0_nxt = 8'h00;
            col1_nxt = 8'h00;
            col2_nxt = 8'h00;
          end
          if (p == POS_TYPE) begin
            type_nxt = in_tdata;
          end
          if (p == POS_CRC_LO) begin
            rcrc_nxt[7:0] = in_tdata;
          end
          if (p == POS_CRC_HI) begin
            rcrc_nxt[15:8] = in_tdata;
          end
          if (is_data && (cidx < COLOUR_LEN)) begin
            case (cidx[1:0])
              2'd0:    col0_nxt = in_tdata;
              2'd1:    col1_nxt = in_tdata;
              default: col2_nxt = in_tdata;
            endcase
          end
          bit_nxt = 3'd0;
          if (is_close) begin
            open_nxt    = 1'b0;
            pos_nxt     = 8'd0;
            closing_nxt = 1'b1;
            if (is_data) begin
              state_nxt = S_STEP;
              pad_nxt   = pad_cnt;
            end else if (pad_cnt != 8'd0) begin
              // The first padding byte starts right away.
              state_nxt = S_STEP;
              pad_nxt   = pad_cnt - 8'd1;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (p >= POS_MAX) begin
            open_nxt  = 1'b0;
            pos_nxt   = 8'd0;
            state_nxt = S_OVR;
          end else begin
            open_nxt    = 1'b1;
            pos_nxt     = p + 8'd1;
            closing_nxt = 1'b0;
            pad_nxt     = 8'd0;
            if (is_data) begin
              state_nxt = S_STEP;
            end
          end
        end
      end
      S_STEP: begin
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          if (pad_r != 8'd0) begin
            pad_nxt = pad_r - 8'd1;
          end else begin
            state_nxt = closing_r ? S_DONE : S_IDLE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (load) begin
            colour_nxt = {col0_r, col1_r, col2_r};
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0,
                           load ? {col2_r, col1_r, col0_r}
                                : {colour_r[7:0], colour_r[15:8], colour_r[23:16]},
                           load, 1'b0, (crc == rcrc_r), type_r};
          state_nxt     = S_IDLE;
        end
      end
      S_OVR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, colour_r[7:0], colour_r[15:8], colour_r[23:16],
                           1'b0, 1'b1, 1'b0, 8'h00};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= 1'b0;
      pos_r       <= 8'd0;
      rcrc_r      <= 16'h0000;
      type_r      <= 8'h00;
      col0_r      <= 8'h00;
      col1_r      <= 8'h00;
      col2_r      <= 8'h00;
      colour_r    <= 24'h000000;
      bit_r       <= 3'd0;
      pad_r       <= 8'd0;
      closing_r   <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= START_RESET;
      end_r       <= END_RESET;
      cmd_r       <= COLOUR_RESET;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      pos_r       <= pos_nxt;
      rcrc_r      <= rcrc_nxt;
      type_r      <= type_nxt;
      col0_r      <= col0_nxt;
      col1_r      <= col1_nxt;
      col2_r      <= col2_nxt;
      colour_r    <= colour_nxt;
      bit_r       <= bit_nxt;
      pad_r       <= pad_nxt;
      closing_r   <= closing_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_START_MARKER:   start_r <= cfg_data;
          REG_END_MARKER:     end_r   <= cfg_data;
          REG_COLOUR_COMMAND: cmd_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cfcr_pkg::*;

  localparam int LIMIT_CYCLES = 10_000_000;
  localparam int HOLD_CYCLES = 8000;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Result fields as they sit in out_tdata, lowest bits last.
  typedef struct packed {
    logic [4:0] pad;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       colour_loaded;
    logic       overrun;
    logic       crc_match;
    logic [7:0] kind;
  } frame_report_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic [7:0]  kind;
    logic        load;
    logic [23:0] rgb;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'h00;

  crc_checked_frame_receiver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver predictor state.
  logic [7:0]  start_mk = START_RESET;
  logic [7:0]  end_mk = END_RESET;
  logic [7:0]  colour_cmd_mk = COLOUR_RESET;
  bit          in_frame = 1'b0;
  logic [7:0]  frame_pos = 8'd0;
  logic [15:0] crc_run = CRC_INIT;
  logic [15:0] crc_rx = 16'h0000;
  logic [7:0]  type_seen = 8'h00;
  logic [7:0]  colour_src [0:2] = '{8'h00, 8'h00, 8'h00};
  logic [23:0] colour_now = 24'h000000;

  frame_report_t pending_reports [$];
  int error_count = 0;
  int cycle_count = 0;
  int fed_bytes = 0;

  // Idling controls, written by the stimulus process and read at clock edges.
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  // Directed frames under the reset settings.
  script_row_t script_rows [0:24] = '{
    '{8'h00, 1'b0, 8'h00, 1'b0, 24'h000000},  // ignored while idle
    '{8'h0A, 1'b0, 8'h00, 1'b0, 24'h000000},  // terminator while idle
    '{8'h55, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h0A, 1'b1, 8'h0A, 1'b0, 24'h000000},  // terminator taken as type
    '{8'hFF, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h03, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h0A, 1'b1, 8'h03, 1'b1, 24'h000000},  // colour frame with no data
    '{8'hFF, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h03, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h80, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h01, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h0A, 1'b1, 8'h03, 1'b1, 24'hFF8001},  // terminator as a data byte
    '{8'hFF, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'hFF, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h0A, 1'b1, 8'hFF, 1'b0, 24'hFF8001},  // terminator as CRC high byte
    '{8'hFF, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 24'h000000},
    '{8'h0A, 1'b1, 8'h00, 1'b0, 24'hFF8001}
  };

  function automatic logic [15:0] crc_ccitt_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // CRC of a data field, with the bytes not given counted as zero.
  function automatic logic [15:0] field_crc(logic [7:0] data [$]);
    logic [15:0] c;
    c = CRC_INIT;
    for (int k = 0; k < DATA_FIELD_LEN; k++)
      c = crc_ccitt_step(c, (k < data.size()) ? data[k] : 8'h00);
    return c;
  endfunction

  function automatic logic [7:0] pick_other_than(logic [7:0] v);
    logic [7:0] x;
    x = 8'($urandom);
    while (x == v) x = 8'($urandom);
    return x;
  endfunction

  task automatic model_byte(input logic [7:0] b, output bit got, output frame_report_t rep);
    logic [7:0]  p;
    logic [15:0] c;
    int          done;
    got = 1'b0;
    rep = '0;
    if (!in_frame) begin
      if (b != start_mk) begin
        return;
      end
      crc_run = CRC_INIT;
      crc_rx = 16'h0000;
      type_seen = 8'h00;
      colour_src = '{8'h00, 8'h00, 8'h00};
      in_frame = 1'b1;
      frame_pos = 8'd0;
    end
    p = frame_pos;
    if (p == POS_TYPE) begin
      type_seen = b;
    end else if (p == POS_CRC_LO) begin
      crc_rx[7:0] = b;
    end else if (p == POS_CRC_HI) begin
      crc_rx[15:8] = b;
    end else if (p >= POS_DATA && {1'b0, p} < POS_DATA_END) begin
      crc_run = crc_ccitt_step(crc_run, b);
      if (p - POS_DATA < COLOUR_LEN) colour_src[p - POS_DATA] = b;
    end
    rep.red = colour_now[23:16];
    rep.green = colour_now[15:8];
    rep.blue = colour_now[7:0];
    if (b == end_mk) begin
      // The rest of the data field is padded with zero bytes.
      done = (p >= POS_DATA) ? int'(p) - int'(POS_DATA) + 1 : 0;
      if (done > DATA_FIELD_LEN) done = DATA_FIELD_LEN;
      c = crc_run;
      for (int k = done; k < DATA_FIELD_LEN; k++) c = crc_ccitt_step(c, 8'h00);
      rep.kind = type_seen;
      rep.crc_match = (c == crc_rx);
      rep.colour_loaded = (type_seen == colour_cmd_mk);
      if (rep.colour_loaded) begin
        colour_now = {colour_src[0], colour_src[1], colour_src[2]};
        rep.red = colour_now[23:16];
        rep.green = colour_now[15:8];
        rep.blue = colour_now[7:0];
      end
      got = 1'b1;
      in_frame = 1'b0;
      frame_pos = 8'd0;
      return;
    end
    if (p >= POS_MAX) begin
      rep.overrun = 1'b1;
      got = 1'b1;
      in_frame = 1'b0;
      frame_pos = 8'd0;
      return;
    end
    frame_pos = p + 8'd1;
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) flag_error($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  task automatic take_report(input frame_report_t got);
    frame_report_t want;
    if (pending_reports.size() == 0) begin
      flag_error($sformatf("result %h with no frame pending", got));
    end else begin
      want = pending_reports.pop_front();
      check_field("frame_kind", got.kind, want.kind);
      check_field("crc_match", got.crc_match, want.crc_match);
      check_field("overrun", got.overrun, want.overrun);
      check_field("colour_loaded", got.colour_loaded, want.colour_loaded);
      check_field("red_level", got.red, want.red);
      check_field("green_level", got.green, want.green);
      check_field("blue_level", got.blue, want.blue);
      check_field("padding", got.pad, 0);
    end
  endtask

  // Result side: checks each transfer, then picks the next ready level.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) take_report(frame_report_t'(out_tdata));
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
        stall_left <= $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Called at a clock edge; returns at the edge where the byte transfers.
  task automatic send_byte(input logic [7:0] b, output bit got, output frame_report_t rep);
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tdata <= b;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_byte(b, got, rep);
    fed_bytes++;
  endtask

  task automatic feed(input logic [7:0] b);
    bit got;
    frame_report_t rep;
    send_byte(b, got, rep);
    if (got) pending_reports.push_back(rep);
  endtask

  task automatic wait_for_reports();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // Consecutive writes keep cfg_valid high; the caller lowers it.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_MARKER:   start_mk = val;
      REG_END_MARKER:     end_mk = val;
      REG_COLOUR_COMMAND: colour_cmd_mk = val;
      default: ;
    endcase
  endtask

  task automatic set_phase(input int ph);
    logic [7:0] s;
    case (ph)
      1: begin
        write_reg(REG_START_MARKER, 8'h00);
        write_reg(REG_END_MARKER, 8'hFF);
        write_reg(REG_COLOUR_COMMAND, 8'h00);
      end
      2: begin
        write_reg(REG_START_MARKER, 8'hFF);
        write_reg(REG_END_MARKER, 8'h00);
        write_reg(REG_COLOUR_COMMAND, 8'hFF);
        write_reg(REG_UNUSED, 8'hA5);
      end
      3: begin
        // Start and end markers equal: every start byte closes an empty frame.
        write_reg(REG_START_MARKER, 8'h5A);
        write_reg(REG_END_MARKER, 8'h5A);
        write_reg(REG_COLOUR_COMMAND, 8'h00);
      end
      4: begin
        s = 8'($urandom);
        write_reg(REG_START_MARKER, s);
        write_reg(REG_END_MARKER, pick_other_than(s));
        write_reg(REG_COLOUR_COMMAND, 8'($urandom));
      end
      default: begin
        write_reg(REG_START_MARKER, START_RESET);
        write_reg(REG_END_MARKER, END_RESET);
        write_reg(REG_COLOUR_COMMAND, COLOUR_RESET);
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame();
    logic [7:0]  data [$];
    logic [15:0] c;
    int          n;
    if (!quiet) begin
      case ($urandom_range(0, 2))
        0: in_gap_pct <= 0;
        1: in_gap_pct <= 10;
        default: in_gap_pct <= 40;
      endcase
      case ($urandom_range(0, 2))
        0: out_stall_pct <= 0;
        1: out_stall_pct <= 10;
        default: out_stall_pct <= 40;
      endcase
      if ($urandom_range(0, 9) == 0) wait_for_reports();
    end
    repeat ($urandom_range(0, 2)) feed(pick_other_than(start_mk));
    if ($urandom_range(0, 6) == 0) begin
      // Broken frame: arbitrary bytes, usually cut short.
      feed(start_mk);
      repeat ($urandom_range(0, 8)) feed(8'($urandom));
      feed(end_mk);
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (n) data.push_back(pick_other_than(end_mk));
      c = field_crc(data);
      if ($urandom_range(0, 1) == 0) c = 16'($urandom);
      feed(start_mk);
      feed(($urandom_range(0, 9) < 3) ? colour_cmd_mk : pick_other_than(end_mk));
      feed(pick_other_than(end_mk));
      feed(c[7:0]);
      feed(c[15:8]);
      foreach (data[i]) feed(data[i]);
      feed(end_mk);
    end
  endtask

  // A full data field, then either the terminator at the last position or
  // one more byte that overruns the frame.
  task automatic send_long(input bit overrun_it);
    logic [7:0]  data [$];
    logic [15:0] c;
    repeat (DATA_FIELD_LEN) data.push_back(pick_other_than(end_mk));
    c = field_crc(data);
    feed(start_mk);
    feed(overrun_it ? pick_other_than(end_mk) : colour_cmd_mk);
    feed(pick_other_than(end_mk));
    feed(overrun_it ? pick_other_than(end_mk) : c[7:0]);
    feed(overrun_it ? pick_other_than(end_mk) : c[15:8]);
    foreach (data[i]) feed(data[i]);
    feed(overrun_it ? pick_other_than(end_mk) : end_mk);
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    stop_at = fed_bytes + budget;
    while (fed_bytes < stop_at) send_frame();
  endtask

  initial begin
    bit got;
    frame_report_t rep;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    out_stall_pct <= 20;
    in_gap_pct <= 20;
    foreach (script_rows[i]) begin
      send_byte(script_rows[i].rx, got, rep);
      if (got && script_rows[i].typed) begin
        // The CRC verdict still comes from the predictor.
        rep.kind = script_rows[i].kind;
        rep.overrun = 1'b0;
        rep.colour_loaded = script_rows[i].load;
        {rep.red, rep.green, rep.blue} = script_rows[i].rgb;
      end
      if (got) pending_reports.push_back(rep);
    end
    run_phase(100);

    for (int ph = 1; ph <= 5; ph++) begin
      wait_for_reports();
      repeat (SETTLE_CYCLES) @(posedge clk);
      set_phase(ph);
      case (ph)
        1: begin
          send_long(1'b0);
          run_phase(80);
        end
        2: begin
          // Long receiver hold-off while frames keep arriving.
          hold_req <= hold_req + 1;
          run_phase(110);
        end
        3: run_phase(40);
        4: begin
          send_long(1'b1);
          run_phase(80);
        end
        default: begin
          quiet <= 1'b1;
          in_gap_pct <= 0;
          out_stall_pct <= 0;
          @(posedge clk);
          run_phase(170);
        end
      endcase
    end

    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
